FILE: sv/smt_pkg.sv
// Package for the sorted multiset table: sizes, command and status codes,
// the control bundle between controller and datapath, and a prefix-OR helper.
// No dependencies.
package smt_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int OCC_W      = 7;
    localparam int FILL_W     = 7;
    localparam int STATUS_W   = 2;
    localparam int CMD_W      = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the item and register the compare vectors
        logic commit;  // update the cells and the result register
    } t_dp_ctrl;

    // Sets every bit at or above the lowest set bit, in log2 steps.
    function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] v);
        logic [CAPACITY-1:0] acc;
        acc = v;
        for (int k = 0; k < $clog2(CAPACITY); k++) begin
            acc = acc | (acc << (1 << k));
        end
        return acc;
    endfunction

endpackage

FILE: sv/smt_if.sv
// Handshake channels of the sorted multiset table: item in, result out and
// the order configuration write. Depends on smt_pkg.
interface smt_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [smt_pkg::CMD_W-1:0]              cmd;
    logic signed [smt_pkg::VALUE_BITS-1:0]  value;
    modport source (output valid, cmd, value, input ready);
    modport sink   (input valid, cmd, value, output ready);
endinterface

interface smt_out_if;
    logic                         valid;
    logic                         ready;
    logic [smt_pkg::STATUS_W-1:0] status;
    logic [smt_pkg::OCC_W-1:0]    occurrences;
    logic [smt_pkg::FILL_W-1:0]   fill_count;
    modport source (output valid, status, occurrences, fill_count, input ready);
    modport sink   (input valid, status, occurrences, fill_count, output ready);
endinterface

interface smt_cfg_if;
    logic valid;
    logic ready;
    logic order_descending;
    modport source (output valid, order_descending, input ready);
    modport sink   (input valid, order_descending, output ready);
endinterface

FILE: sv/smt_ctrl.sv
// Controller of the sorted multiset table: takes an item, then commits it
// into the result register once that register is free. Depends on smt_pkg.
module smt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output smt_pkg::t_dp_ctrl o_ctrl
);

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    // The result register can take a new beat when empty or being drained.
    assign out_free      = !r_out_valid || i_out_ready;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_ctrl.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_ctrl.commit = (r_state == S_APPLY) && out_free;
    assign o_out_valid   = r_out_valid;

    // State and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_ctrl.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: sv/smt_dp.sv
// Datapath of the sorted multiset table: a row of value cells with parallel
// compare, the shift network for insert and delete, and the result register.
// Depends on smt_pkg.
module smt_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  smt_pkg::t_dp_ctrl                     i_ctrl,
    input  logic [smt_pkg::CMD_W-1:0]             i_cmd,
    input  logic signed [smt_pkg::VALUE_BITS-1:0] i_value,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_desc,
    output logic [smt_pkg::STATUS_W-1:0]          o_status,
    output logic [smt_pkg::OCC_W-1:0]             o_occurrences,
    output logic [smt_pkg::FILL_W-1:0]            o_fill_count
);

    localparam int CAP = smt_pkg::CAPACITY;
    localparam int VW  = smt_pkg::VALUE_BITS;
    localparam int CW  = smt_pkg::CNT_W;

    logic signed [VW-1:0]        r_cells [CAP];
    logic signed [VW-1:0]        n_cells [CAP];
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic                        r_order;
    smt_pkg::t_cmd               r_cmd;
    logic signed [VW-1:0]        r_value;
    logic [CAP-1:0]              r_after;
    logic [CAP-1:0]              r_eq;
    logic [CAP-1:0]              used;
    logic [CAP-1:0]              ins_ge;
    logic [CAP-1:0]              rem_ge;
    logic                        full;
    logic                        found;
    smt_pkg::t_status            n_status;
    logic [smt_pkg::OCC_W-1:0]   n_occ;
    logic [smt_pkg::STATUS_W-1:0] r_status;
    logic [smt_pkg::OCC_W-1:0]   r_occ;
    logic [smt_pkg::FILL_W-1:0]  r_fill;

    // Thermometer of cells that currently hold an entry.
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            used[i] = (CW'(i) < r_count);
        end
    end

    // Order register; the user must write it only while the block is idle, the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b0;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_desc;
        end
    end

    // Capture the item and compare it against every held cell at once.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd   <= smt_pkg::t_cmd'(i_cmd);
            r_value <= i_value;
            for (int i = 0; i < CAP; i++) begin
                r_after[i] <= used[i] &&
                              (r_order ? (r_cells[i] < i_value) : (r_cells[i] > i_value));
                r_eq[i]    <= used[i] && (r_cells[i] == i_value);
            end
        end
    end

    // Insert goes at the first cell that sorts strictly after the value,
    // or at the end; delete takes out the first equal cell.
    assign ins_ge = smt_pkg::prefix_or(r_after | ~used);
    assign rem_ge = smt_pkg::prefix_or(r_eq);
    assign full   = (r_count == CW'(CAP));
    assign found  = |r_eq;

    // Next cell contents, status and count for the captured command.
    always_comb begin
        n_cells  = r_cells;
        n_count  = r_count;
        n_status = smt_pkg::ST_DONE;
        n_occ    = '0;
        unique case (r_cmd)
            smt_pkg::CMD_ADD: begin
                if (full) begin
                    n_status = smt_pkg::ST_FULL;
                end else begin
                    for (int i = 0; i < CAP; i++) begin
                        if (i == 0) begin
                            if (ins_ge[0]) n_cells[0] = r_value;
                        end else if (ins_ge[i - 1]) begin
                            n_cells[i] = r_cells[i - 1];
                        end else if (ins_ge[i]) begin
                            n_cells[i] = r_value;
                        end
                    end
                    n_count = r_count + CW'(1);
                end
            end
            smt_pkg::CMD_REMOVE: begin
                if (!found) begin
                    n_status = smt_pkg::ST_MISSING;
                end else begin
                    for (int i = 0; i < CAP - 1; i++) begin
                        if (rem_ge[i]) n_cells[i] = r_cells[i + 1];
                    end
                    n_count = r_count - CW'(1);
                end
            end
            smt_pkg::CMD_QUERY: begin
                n_occ = smt_pkg::OCC_W'($countones(r_eq));
            end
            default: begin
                n_status = smt_pkg::ST_DONE;
            end
        endcase
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.commit) begin
            r_count <= n_count;
        end
    end

    // Cells and result register.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit) begin
            r_cells  <= n_cells;
            r_status <= n_status;
            r_occ    <= n_occ;
            r_fill   <= smt_pkg::FILL_W'(n_count);
        end
    end

    assign o_status      = r_status;
    assign o_occurrences = r_occ;
    assign o_fill_count  = r_fill;

endmodule

FILE: sv/sorted_multiset_table_top.sv
// Top level of the sorted multiset table: joins controller and datapath to
// the item, result and configuration channels. Depends on smt_pkg, smt_if,
// smt_ctrl and smt_dp.
//
//   channel  direction  contents                           handshake
//   i_in     in         cmd, value                         valid / ready
//   o_out    out        status, occurrences, fill_count    valid / ready
//   i_cfg    in         order_descending                   valid / ready (always ready)
//
// The accept edge registers the compare of the value against all 64 cells;
// the commit edge, taken in the apply state, shifts the cells and loads the
// result register. One item is in flight at a time; a new item is taken
// while the previous result still waits in the result register. A stalled
// result holds the block in its apply state. Reset empties the store and
// selects ascending order; cell contents need no reset.
module sorted_multiset_table_top (
    input  logic   i_clk,
    input  logic   i_rst_n,
    smt_in_if.sink    i_in,
    smt_out_if.source o_out,
    smt_cfg_if.sink   i_cfg
);

    smt_pkg::t_dp_ctrl ctrl;

    assign i_cfg.ready = 1'b1;

    // Sequencing.
    smt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_ctrl      (ctrl)
    );

    // Cells, compare and shift network.
    smt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_cmd         (i_in.cmd),
        .i_value       (i_in.value),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_desc    (i_cfg.order_descending),
        .o_status      (o_out.status),
        .o_occurrences (o_out.occurrences),
        .o_fill_count  (o_out.fill_count)
    );

endmodule

FILE: sv/smt_checker.sv
// Port-level checks of the sorted multiset table and the bind that attaches
// them to the top level. Depends on smt_pkg and sorted_multiset_table_top.
module smt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [smt_pkg::STATUS_W-1:0]  i_status,
    input logic [smt_pkg::OCC_W-1:0]     i_occ,
    input logic [smt_pkg::FILL_W-1:0]    i_fill
);

    // The fill count never passes the capacity.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_fill <= smt_pkg::FILL_W'(smt_pkg::CAPACITY)))
        else $error("fill count above capacity");

    // A query cannot count more entries than are held.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_occ <= i_fill))
        else $error("occurrences above fill count");

    // A refused add only happens with the store full.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == smt_pkg::ST_FULL)) |->
        (i_fill == smt_pkg::FILL_W'(smt_pkg::CAPACITY)))
        else $error("full status with room left");

    // Items are never accepted back to back.
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !(i_in_valid && i_in_ready))
        else $error("items accepted back to back");

    // A stalled result beat holds its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_status) && $stable(i_occ) && $stable(i_fill)))
        else $error("stalled result changed");

endmodule

bind sorted_multiset_table_top smt_checker u_smt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_occ       (o_out.occurrences),
    .i_fill      (o_out.fill_count)
);

FILE: tb/sorted_multiset_table_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted multiset table: a tracker predicts each
// result from accepted item beats and checks the result beats in order.
// Depends on smt_pkg, smt_if and sorted_multiset_table_top.
module sorted_multiset_table_top_tb;

    localparam logic [smt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [smt_pkg::VALUE_BITS-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [smt_pkg::VALUE_BITS-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [smt_pkg::STATUS_W-1:0] status;
        logic [smt_pkg::OCC_W-1:0]    occ;
        logic [smt_pkg::FILL_W-1:0]   fill;
    } t_result;

    // Tracks the expected contents of the store and the results still owed.
    class multiset_tracker;
        logic signed [smt_pkg::VALUE_BITS-1:0] held[$];
        bit                                    descending;
        t_result                               owed_results[$];
        int unsigned                           errors;

        function bit comes_after(logic signed [smt_pkg::VALUE_BITS-1:0] a,
                                 logic signed [smt_pkg::VALUE_BITS-1:0] b);
            return descending ? (a < b) : (a > b);
        endfunction

        function void note_item(logic [smt_pkg::CMD_W-1:0] cmd,
                                logic signed [smt_pkg::VALUE_BITS-1:0] value);
            t_result res;
            int      pos;
            bit      found;
            res.status = smt_pkg::ST_DONE;
            res.occ    = '0;
            found      = 1'b0;
            pos        = held.size();
            case (cmd)
                smt_pkg::CMD_ADD: begin
                    if (held.size() >= smt_pkg::CAPACITY) begin
                        res.status = smt_pkg::ST_FULL;
                    end else begin
                        // A new value goes after every entry that is not strictly after it.
                        for (int i = 0; i < held.size(); i++) begin
                            if (!found && comes_after(held[i], value)) begin
                                pos   = i;
                                found = 1'b1;
                            end
                        end
                        held.insert(pos, value);
                    end
                end
                smt_pkg::CMD_REMOVE: begin
                    for (int i = 0; i < held.size(); i++) begin
                        if (!found && held[i] == value) begin
                            pos   = i;
                            found = 1'b1;
                        end
                    end
                    if (found) held.delete(pos);
                    else res.status = smt_pkg::ST_MISSING;
                end
                smt_pkg::CMD_QUERY: begin
                    for (int i = 0; i < held.size(); i++) begin
                        if (held[i] == value) res.occ = res.occ + 1'b1;
                    end
                end
                default: ;
            endcase
            res.fill = smt_pkg::FILL_W'(held.size());
            owed_results.push_back(res);
        endfunction

        function void check_result(logic [smt_pkg::STATUS_W-1:0] status,
                                   logic [smt_pkg::OCC_W-1:0] occ,
                                   logic [smt_pkg::FILL_W-1:0] fill);
            t_result exp_res;
            if (owed_results.size() == 0) begin
                $display("%0t: result beat with none expected: status %0d occ %0d fill %0d",
                         $time, status, occ, fill);
                errors++;
                return;
            end
            exp_res = owed_results.pop_front();
            if (status !== exp_res.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, exp_res.status, status);
                errors++;
            end
            if (occ !== exp_res.occ) begin
                $display("%0t: occurrences mismatch: expected %0d actual %0d",
                         $time, exp_res.occ, occ);
                errors++;
            end
            if (fill !== exp_res.fill) begin
                $display("%0t: fill_count mismatch: expected %0d actual %0d",
                         $time, exp_res.fill, fill);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    smt_in_if  in_ch ();
    smt_out_if out_ch ();
    smt_cfg_if cfg_ch ();

    multiset_tracker tracker = new();

    sorted_multiset_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // 100 MHz clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Result beats are checked at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            tracker.check_result(out_ch.status, out_ch.occurrences, out_ch.fill_count);
        end
    end

    // Result-side backpressure: ready runs and stalls of random length.
    initial begin
        int run_left;
        logic ready_now;
        int r;
        out_ch.ready = 1'b0;
        run_left     = 0;
        ready_now    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    ready_now = 1'b1;
                    run_left  = $urandom_range(1, 8);
                end else if (r < 62) begin
                    ready_now = 1'b1;
                    run_left  = $urandom_range(50, 150);
                end else if (r < 93) begin
                    ready_now = 1'b0;
                    run_left  = $urandom_range(1, 3);
                end else begin
                    ready_now = 1'b0;
                    run_left  = $urandom_range(15, 40);
                end
            end
            out_ch.ready <= ready_now;
            run_left--;
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap(bit no_gaps);
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [smt_pkg::VALUE_BITS-1:0] pick_value(
        logic [smt_pkg::CMD_W-1:0] cmd);
        int r;
        r = $urandom_range(0, 99);
        // Removes and queries often aim at a value that is held.
        if (cmd != smt_pkg::CMD_ADD && tracker.held.size() != 0 && r < 40) begin
            return tracker.held[$urandom_range(0, tracker.held.size() - 1)];
        end
        r = $urandom_range(0, 99);
        if (r < 50) return $signed($urandom_range(0, 6)) - 3;
        if (r < 65) begin
            case ($urandom_range(0, 5))
                0: return VAL_MIN;
                1: return VAL_MIN + 1;
                2: return VAL_MAX;
                3: return VAL_MAX - 1;
                4: return '0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    // Drives one item beat; called and returns at a falling edge.
    task automatic send_item(logic [smt_pkg::CMD_W-1:0] cmd,
                             logic signed [smt_pkg::VALUE_BITS-1:0] value,
                             bit no_gaps);
        int gap;
        gap = pick_gap(no_gaps);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= cmd;
        in_ch.value <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        tracker.note_item(cmd, value);
        @(negedge i_clk);
    endtask

    // Stops the item stream and waits until every owed result has arrived.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (tracker.owed_results.size() != 0) @(negedge i_clk);
    endtask

    // Writes the order register while the block is idle.
    task automatic write_order(bit descending);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.order_descending <= descending;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        tracker.descending = descending;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One random phase: drain, set the order, then a command mix given in percent.
    task automatic run_phase(bit descending, int add_pct, int rem_pct, int qry_pct,
                             int count, bit no_gaps);
        int r;
        logic [smt_pkg::CMD_W-1:0] cmd;
        drain();
        write_order(descending);
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < add_pct) cmd = smt_pkg::CMD_ADD;
            else if (r < add_pct + rem_pct) cmd = smt_pkg::CMD_REMOVE;
            else if (r < add_pct + rem_pct + qry_pct) cmd = smt_pkg::CMD_QUERY;
            else cmd = CMD_UNUSED;
            send_item(cmd, pick_value(cmd), no_gaps);
        end
    endtask

    // Reset, directed items, random phases, then the verdict.
    initial begin
        i_rst_n                 = 1'b0;
        in_ch.valid             = 1'b0;
        in_ch.cmd               = smt_pkg::CMD_ADD;
        in_ch.value             = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.order_descending = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty store, extremes, equal entries, misses, unused code.
        write_order(1'b0);
        send_item(smt_pkg::CMD_QUERY, '0, 1'b0);
        send_item(smt_pkg::CMD_REMOVE, 5, 1'b0);
        send_item(smt_pkg::CMD_ADD, VAL_MAX, 1'b0);
        send_item(smt_pkg::CMD_ADD, VAL_MIN, 1'b1);
        send_item(smt_pkg::CMD_ADD, -1, 1'b1);
        send_item(smt_pkg::CMD_ADD, '0, 1'b0);
        send_item(smt_pkg::CMD_ADD, '0, 1'b1);
        send_item(smt_pkg::CMD_ADD, -1, 1'b0);
        send_item(smt_pkg::CMD_QUERY, '0, 1'b1);
        send_item(smt_pkg::CMD_QUERY, VAL_MIN, 1'b0);
        send_item(CMD_UNUSED, VAL_MIN, 1'b0);
        send_item(smt_pkg::CMD_REMOVE, '0, 1'b1);
        send_item(smt_pkg::CMD_REMOVE, 42, 1'b0);
        send_item(smt_pkg::CMD_REMOVE, VAL_MAX, 1'b0);
        send_item(smt_pkg::CMD_QUERY, -1, 1'b0);
        send_item(smt_pkg::CMD_QUERY, VAL_MAX, 1'b1);

        // Random phases: the order flips with entries still held, the store
        // fills past capacity and drains past empty.
        run_phase(1'b1, 85, 5, 8, 250, 1'b0);
        run_phase(1'b1, 10, 70, 15, 250, 1'b1);
        run_phase(1'b0, 40, 35, 20, 300, 1'b0);
        run_phase(1'b0, 80, 10, 8, 250, 1'b1);
        run_phase(1'b1, 40, 35, 20, 300, 1'b0);
        run_phase(1'b0, 10, 70, 15, 200, 1'b0);
        run_phase(1'b1, 45, 30, 20, 300, 1'b0);

        drain();
        repeat (8) @(negedge i_clk);
        if (tracker.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/smt_pkg.sv
sv/smt_if.sv
sv/smt_ctrl.sv
sv/smt_dp.sv
sv/sorted_multiset_table_top.sv
sv/smt_checker.sv
tb/sorted_multiset_table_top_tb.sv
